// ===== rtl/slri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list package
// Shared types and constants for the sorted list with insert and remove.
// ----------------------------------------------------------------------------
package slri_pkg;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    // Command codes
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    typedef logic signed [VALUE_W-1:0] t_value;

    // Largest value reported while the list is empty
    localparam t_value EMPTY_LARGEST = 32'sd1000;

    // Command beat
    typedef struct packed {
        logic   cmd;
        t_value value;
    } t_cmd;

    // Result beat
    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] count;
        logic               is_empty;
        logic               is_full;
        t_value             largest;
    } t_res;

    // Control broadcast to every cell
    typedef struct packed {
        logic   ins_en;
        logic   rem_en;
        t_value x;
    } t_cell_ctl;

    // Compare flags from one cell, gated by occupancy
    typedef struct packed {
        logic ge;
        logic gt;
    } t_cell_flags;

endpackage

// ===== rtl/slri_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list channels
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface slri_cmd_if;
    import slri_pkg::*;

    logic valid;
    logic ready;
    t_cmd data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface slri_res_if;
    import slri_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/slri_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list cell
// Holds one entry of the descending list, compares it with the command value
// and takes its neighbour's entry when an insert or remove moves the list.
// ----------------------------------------------------------------------------
module slri_cell (
    input  logic                  i_clk,
    input  slri_pkg::t_cell_ctl   i_ctl,
    input  logic                  i_occ,
    input  logic                  i_prev_ge,
    input  slri_pkg::t_value      i_prev_val,
    input  slri_pkg::t_value      i_next_val,
    output slri_pkg::t_cell_flags o_flags,
    output slri_pkg::t_value      o_val,
    output slri_pkg::t_value      o_nval
);
    import slri_pkg::*;

    t_value r_val;
    t_value n_val;

    // Compare the held entry with the command value
    always_comb begin
        o_flags.ge = i_occ && (r_val >= i_ctl.x);
        o_flags.gt = i_occ && (r_val >  i_ctl.x);
    end

    // Insert: cells below the new value move down one place, the first one
    // takes the value. Remove: cells from the match onward move up one place.
    always_comb begin
        n_val = r_val;
        if (i_ctl.ins_en && !o_flags.ge) begin
            n_val = i_prev_ge ? i_ctl.x : i_prev_val;
        end else if (i_ctl.rem_en && !o_flags.gt) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val  = r_val;
    assign o_nval = n_val;

endmodule

// ===== rtl/sorted_list_insert_remove.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list with insert and remove
// Holds up to CAPACITY signed values in a row of cells, kept in descending
// order from cell 0, so the largest value always sits in cell 0.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries one command per beat: cmd 0 inserts value, cmd 1 removes
//   the first stored copy of value. o_res carries one result per command:
//   ok, count, is_empty, is_full and largest, all showing the list after the
//   command (largest reads 1000 while the list is empty).
//   An insert into a full list, or a remove of an absent value, leaves the
//   list unchanged and returns ok low.
//   The result beat is registered and follows the command beat in the next
//   cycle. Every cell compares and shifts in the same cycle, so one command is
//   taken per cycle while results are taken; the rate is set by the compare
//   across the row and the match reduction that gates the remove shift.
//   When the receiver stalls the result holds in the output register and
//   i_cmd.ready drops until that beat is taken; a command is taken in the
//   same cycle as the waiting result leaves.
//   Reset empties the list and drops the output valid. Cell contents are not
//   cleared: only entries below the count are ever looked at.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove #(
    parameter int CAPACITY = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    slri_cmd_if.sink   i_cmd,
    slri_res_if.source o_res
);
    import slri_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_ovalid;
    t_res             r_res;
    t_res             n_res;

    logic             w_accept;
    logic             w_found;
    logic             w_full;
    t_cell_ctl        w_ctl;
    logic             w_occ   [CAPACITY];
    t_cell_flags      w_flags [CAPACITY];
    t_value           w_val   [CAPACITY];
    t_value           w_nval  [CAPACITY];
    logic [CNT_W+4:0] w_count_wide;

    // Take a command whenever the output register is free or being emptied
    assign i_cmd.ready = !r_ovalid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;
    assign w_full      = (r_count == CAP_CNT);

    // Any occupied cell holding the value
    always_comb begin
        w_found = 1'b0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_found = w_found | (w_occ[i] && (w_val[i] == i_cmd.data.value));
        end
    end

    // Broadcast the operation to the row
    always_comb begin
        w_ctl.x      = i_cmd.data.value;
        w_ctl.ins_en = w_accept && (i_cmd.data.cmd == OP_INSERT) && !w_full;
        w_ctl.rem_en = w_accept && (i_cmd.data.cmd == OP_REMOVE) && w_found;
    end

    // Row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            if (CAPACITY > 1) begin : g_more
                slri_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (w_ctl),
                    .i_occ      (w_occ[g]),
                    .i_prev_ge  (1'b1),
                    .i_prev_val (w_ctl.x),
                    .i_next_val (w_val[g+1]),
                    .o_flags    (w_flags[g]),
                    .o_val      (w_val[g]),
                    .o_nval     (w_nval[g])
                );
            end else begin : g_only
                slri_cell u_cell (
                    .i_clk      (i_clk),
                    .i_ctl      (w_ctl),
                    .i_occ      (w_occ[g]),
                    .i_prev_ge  (1'b1),
                    .i_prev_val (w_ctl.x),
                    .i_next_val (w_val[g]),
                    .o_flags    (w_flags[g]),
                    .o_val      (w_val[g]),
                    .o_nval     (w_nval[g])
                );
            end
        end else if (g == CAPACITY - 1) begin : g_last
            slri_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_occ      (w_occ[g]),
                .i_prev_ge  (w_flags[g-1].ge),
                .i_prev_val (w_val[g-1]),
                .i_next_val (w_val[g]),
                .o_flags    (w_flags[g]),
                .o_val      (w_val[g]),
                .o_nval     (w_nval[g])
            );
        end else begin : g_mid
            slri_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (w_ctl),
                .i_occ      (w_occ[g]),
                .i_prev_ge  (w_flags[g-1].ge),
                .i_prev_val (w_val[g-1]),
                .i_next_val (w_val[g+1]),
                .o_flags    (w_flags[g]),
                .o_val      (w_val[g]),
                .o_nval     (w_nval[g])
            );
        end
    end

    // Advance the count
    always_comb begin
        n_count = r_count;
        if (w_ctl.ins_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.rem_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Build the result beat from the state after the command
    assign w_count_wide = {5'b0, n_count};

    always_comb begin
        n_res.ok       = w_ctl.ins_en || w_ctl.rem_en;
        n_res.count    = w_count_wide[COUNT_W-1:0];
        n_res.is_empty = (n_count == '0);
        n_res.is_full  = (n_count == CAP_CNT);
        n_res.largest  = (n_count == '0) ? EMPTY_LARGEST : w_nval[0];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Hold the result beat until it is taken
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_res;

endmodule

// ===== rtl/slri_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list port checker
// Watches the command and result channels of the sorted list.
// ----------------------------------------------------------------------------
module slri_checker #(
    parameter int CAPACITY = 16
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input slri_pkg::t_res i_out_data
);
    import slri_pkg::*;

    // Every accepted command yields a result beat on the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("no result after accepted command");

    // An empty list reports the empty sentinel as its largest value
    a_empty_largest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.is_empty) |->
            (i_out_data.largest == EMPTY_LARGEST && i_out_data.count == '0))
        else $error("empty result with wrong largest or count");

    // Empty and full never show together, and full shows the capacity
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_data.is_full) |->
            (!i_out_data.is_empty && i_out_data.count == COUNT_W'(CAPACITY)))
        else $error("full result inconsistent");

    // A stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_data)))
        else $error("stalled result changed");

endmodule

bind sorted_list_insert_remove slri_checker #(.CAPACITY(CAPACITY)) u_slri_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_data  (o_res.data)
);
